// ===== hw/rtl/binary_to_decimal_ascii_unit_defines.svh =====
// assertion macros for the binary to decimal ascii unit
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// checked only outside reset
`define B2DA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define B2DA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/b2da_pkg.sv =====
// shared types and constants of the binary to decimal ascii unit
`default_nettype none

package b2da_pkg;

   localparam int DEFAULT_VALUE_BITS  = 16;
   localparam int DEFAULT_DIGIT_COUNT = 5;

   localparam int DIGIT_W = 4;
   localparam int ASCII_W = 6;

   localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'h30;

   // what every cell of the digit row does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_SHIFT,
      CELL_MOVE
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/b2da_cell.sv =====
// one decimal digit cell of the double dabble row
`default_nettype none

module b2da_cell (
   input  wire logic                          clock,
   input  wire b2da_pkg::cell_op_type         cell_op,
   input  wire logic                          bit_in,
   input  wire logic [b2da_pkg::DIGIT_W-1:0]  digit_in,
   output logic                               bit_out,
   output logic      [b2da_pkg::DIGIT_W-1:0]  digit_out
);

   logic [b2da_pkg::DIGIT_W-1:0] digit_ff;
   logic [b2da_pkg::DIGIT_W-1:0] digit_next_in;
   logic [b2da_pkg::DIGIT_W-1:0] adjusted;

   // add 3 before the shift so the digit carries at ten
   always_comb begin
      adjusted = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
      bit_out  = adjusted[b2da_pkg::DIGIT_W-1];
      case (cell_op)
         b2da_pkg::CELL_HOLD:  digit_next_in = digit_ff;
         b2da_pkg::CELL_CLEAR: digit_next_in = '0;
         b2da_pkg::CELL_SHIFT: digit_next_in = {adjusted[b2da_pkg::DIGIT_W-2:0], bit_in};
         b2da_pkg::CELL_MOVE:  digit_next_in = digit_in;
         default:              digit_next_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_next_in;
   end

   assign digit_out = digit_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/binary_to_decimal_ascii_unit.sv =====
// steps: a word is accepted, its VALUE_BITS bits are shifted into the row of digit cells
// by the bit-serial double dabble pass, then the digit positions are emitted from the top,
// most significant first, and a valid digit is held while rsp_stall is high
// leading zero positions are passed over but give no word
// one word at a time: a new value is taken only after the last digit is delivered
// reset returns the sequencer to idle; digit cells are cleared on every accepted word
`default_nettype none

`include "binary_to_decimal_ascii_unit_defines.svh"

module binary_to_decimal_ascii_unit #(
   parameter int VALUE_BITS  = b2da_pkg::DEFAULT_VALUE_BITS,
   parameter int DIGIT_COUNT = b2da_pkg::DEFAULT_DIGIT_COUNT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [VALUE_BITS-1:0]         req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [b2da_pkg::ASCII_W-1:0]  rsp_ascii_digit,
   output logic                               rsp_last_digit
);

   localparam int BIT_CNT_W = $clog2(VALUE_BITS);
   localparam int REM_W     = $clog2(DIGIT_COUNT + 1);

   b2da_pkg::state_type    state_ff, state_in;
   b2da_pkg::cell_op_type  cell_op;

   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic                   seen_ff, seen_in;

   logic [b2da_pkg::DIGIT_W-1:0] digit_w [DIGIT_COUNT];
   logic                         carry_w [DIGIT_COUNT+1];
   logic [b2da_pkg::DIGIT_W-1:0] top_digit;
   logic                         top_nonzero;
   logic                         rsp_take;

   assign carry_w[0] = value_ff[VALUE_BITS-1];

   genvar k;
   generate
      for (k = 0; k < DIGIT_COUNT; k++) begin : g_cell
         logic [b2da_pkg::DIGIT_W-1:0] lower_digit;
         if (k == 0) begin : g_first
            assign lower_digit = '0;
         end else begin : g_rest
            assign lower_digit = digit_w[k-1];
         end
         b2da_cell u_cell (
            .clock     (clock),
            .cell_op   (cell_op),
            .bit_in    (carry_w[k]),
            .digit_in  (lower_digit),
            .bit_out   (carry_w[k+1]),
            .digit_out (digit_w[k])
         );
      end
   endgenerate

   assign top_digit   = digit_w[DIGIT_COUNT-1];
   assign top_nonzero = (top_digit != '0);

   // a leading zero is skipped unless it is the only digit left
   assign rsp_valid = (state_ff == b2da_pkg::ST_EMIT) &&
                      (seen_ff || top_nonzero || (rem_ff == REM_W'(1)));
   assign rsp_take  = rsp_valid && !rsp_stall;

   assign rsp_ascii_digit = b2da_pkg::ASCII_ZERO +
                            {{(b2da_pkg::ASCII_W-b2da_pkg::DIGIT_W){1'b0}}, top_digit};
   assign rsp_last_digit  = (rem_ff == REM_W'(1));
   assign req_stall       = (state_ff != b2da_pkg::ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      value_in   = value_ff;
      bit_cnt_in = bit_cnt_ff;
      rem_in     = rem_ff;
      seen_in    = seen_ff;
      cell_op    = b2da_pkg::CELL_HOLD;
      case (state_ff)
         b2da_pkg::ST_IDLE: begin
            if (req_valid) begin
               value_in   = req_value;
               bit_cnt_in = '0;
               seen_in    = 1'b0;
               cell_op    = b2da_pkg::CELL_CLEAR;
               state_in   = b2da_pkg::ST_CONVERT;
            end
         end
         b2da_pkg::ST_CONVERT: begin
            cell_op    = b2da_pkg::CELL_SHIFT;
            value_in   = {value_ff[VALUE_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_BITS - 1)) begin
               rem_in   = REM_W'(DIGIT_COUNT);
               state_in = b2da_pkg::ST_EMIT;
            end
         end
         b2da_pkg::ST_EMIT: begin
            if (!rsp_valid || rsp_take) begin
               cell_op = b2da_pkg::CELL_MOVE;
               rem_in  = rem_ff - REM_W'(1);
               seen_in = seen_ff || rsp_valid;
               if (rem_ff == REM_W'(1)) begin
                  state_in = b2da_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = b2da_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2da_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      bit_cnt_ff <= bit_cnt_in;
      rem_ff     <= rem_in;
      seen_ff    <= seen_in;
   end

   `B2DA_ASSERT(a_last_ends_run, (rsp_take && rsp_last_digit) |=> (!rsp_valid && state_ff == b2da_pkg::ST_IDLE), "word continues after last digit")
   `B2DA_ASSERT(a_accept_starts, (req_valid && !req_stall) |=> (state_ff == b2da_pkg::ST_CONVERT && bit_cnt_ff == '0), "accepted word did not start conversion")
   `B2DA_ASSERT(a_digit_range, rsp_valid |-> (top_digit <= 4'd9), "digit cell holds a non-decimal code")
   `B2DA_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == b2da_pkg::ST_IDLE), "sequencer not idle after reset")

endmodule

`default_nettype wire
